[rtl/rdc_pkg.sv]
// Package for the radix digit converter: field widths, radix limits,
// ASCII constants and the digit-to-character function.
// No dependencies.
package rdc_pkg;

  localparam int VALUE_BITS_DEF  = 31;
  localparam int DIGIT_DEPTH_DEF = 32;

  localparam int BASE_BITS  = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 8;

  localparam logic [BASE_BITS-1:0]  MIN_BASE      = 6'd2;
  localparam logic [BASE_BITS-1:0]  MAX_BASE      = 6'd36;
  localparam logic [DIGIT_BITS-1:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_A        = 8'h41;

  // Digits below ten map to '0'..'9', the rest to 'A' onward.
  function automatic logic [CHAR_BITS-1:0] ascii_of(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] d_ext;
    d_ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
    if (d < DECIMAL_LIMIT) begin
      ascii_of = CHAR_ZERO + d_ext;
    end else begin
      ascii_of = CHAR_A + d_ext - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DECIMAL_LIMIT};
    end
  endfunction

endpackage

[rtl/radix_digit_converter.sv]
// Radix digit converter top level: converts an integer to base-N digits.
// Each digit is produced by the bit-serial divider and pushed onto the digit RAM;
// the digits are then popped from the digit RAM one at a time and presented.
// A new value is accepted only once every digit of the last one has been taken.
// A bad base or a zero value gives its single result, registered, in the next cycle.
// Reset (rst_n, synchronous, active low) clears the sequencer and output valid.
module radix_digit_converter #(
  parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = rdc_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [VALUE_BITS-1:0]          in_value,
  input  logic [rdc_pkg::BASE_BITS-1:0]  in_base,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rdc_pkg::DIGIT_BITS-1:0] out_digit_value,
  output logic [rdc_pkg::CHAR_BITS-1:0]  out_digit_char,
  output logic                           out_last_digit,
  output logic                           out_empty_result,
  output logic                           out_bad_base
);
  import rdc_pkg::*;

  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int SW = $clog2(DIGIT_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic [SW-1:0] sp_dec;

  logic                  out_valid_r, out_valid_nxt;
  logic [DIGIT_BITS-1:0] out_digit_r, out_digit_nxt;
  logic [CHAR_BITS-1:0]  out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_bad_r, out_bad_nxt;

  logic                  in_accept;
  logic                  out_take;
  logic                  base_bad;
  logic                  value_zero;
  logic [BASE_BITS-1:0]  base_r, base_nxt;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [BASE_BITS-1:0]  div_remainder;

  logic                  ram_we;
  logic                  ram_re;
  logic [DIGIT_BITS-1:0] ram_rdata;

  assign in_stall   = (state_r != S_IDLE) || out_valid_r;
  assign in_accept  = in_valid && !in_stall;
  assign out_take   = out_valid_r && !out_stall;
  assign base_bad   = (in_base < MIN_BASE) || (in_base > MAX_BASE);
  assign value_zero = (in_value == '0);
  assign sp_dec     = sp_r - SW'(1);

  // Divider start: first digit from the input, later ones from the quotient.
  assign div_start = (in_accept && !base_bad && !value_zero) ||
                     ((state_r == S_DIV) && div_done && (div_quotient != '0));
  assign div_dividend = (state_r == S_IDLE) ? in_value : div_quotient;

  // Push a remainder while the stack has room; later digits are dropped.
  assign ram_we = (state_r == S_DIV) && div_done && (sp_r < SW'(DIGIT_DEPTH));
  assign ram_re = (state_r == S_POP) && (!out_valid_r || !out_stall);

  rdc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((state_r == S_IDLE) ? in_base : base_r),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  rdc_ram #(
    .WIDTH (DIGIT_BITS),
    .DEPTH (DIGIT_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_r[AW-1:0]),
    .wdata (div_remainder),
    .re    (ram_re),
    .raddr (sp_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    base_nxt      = base_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_digit_nxt = out_digit_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (base_bad || value_zero) begin
            out_valid_nxt = 1'b1;
            out_digit_nxt = '0;
            out_char_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = !base_bad;
            out_bad_nxt   = base_bad;
          end else begin
            base_nxt  = in_base;
            sp_nxt    = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (ram_we) begin
            sp_nxt = sp_r + SW'(1);
          end
          if (div_quotient == '0) begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (ram_re) begin
          sp_nxt    = sp_dec;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_digit_nxt = ram_rdata;
        out_char_nxt  = ascii_of(ram_rdata);
        out_last_nxt  = (sp_r == '0);
        out_empty_nxt = 1'b0;
        out_bad_nxt   = 1'b0;
        state_nxt     = (sp_r == '0) ? S_IDLE : S_POP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    out_digit_r <= out_digit_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_digit_value  = out_digit_r;
  assign out_digit_char   = out_char_r;
  assign out_last_digit   = out_last_r;
  assign out_empty_result = out_empty_r;
  assign out_bad_base     = out_bad_r;

endmodule

[rtl/rdc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rdc_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rdc_pkg for the radix width.
module rdc_divider #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [rdc_pkg::BASE_BITS-1:0]  divisor,
  output logic                           done,
  output logic [VALUE_BITS-1:0]          quotient,
  output logic [rdc_pkg::BASE_BITS-1:0]  remainder
);
  import rdc_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [BASE_BITS-1:0]  rem_r, rem_nxt;
  logic [BASE_BITS-1:0]  div_r, div_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [BASE_BITS:0] rem_sh;
  logic [BASE_BITS:0] rem_sub;
  logic               ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh  = {rem_r, q_r[VALUE_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});

  // Sequencing of the iterations.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = CW'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_BITS-2:0], ge};
      rem_nxt = ge ? rem_sub[BASE_BITS-1:0] : rem_sh[BASE_BITS-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule
